// ----- src/pixel_charge_share_accumulator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the pixel charge-share accumulator checkers.
// ----------------------------------------------------------------------------
`ifndef PIXEL_CHARGE_SHARE_ACCUMULATOR_CORE_ASSERT_SVH
`define PIXEL_CHARGE_SHARE_ACCUMULATOR_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset
`define PCSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define PCSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsa_pkg
// Types and constants of the pixel charge-share accumulator.
// ----------------------------------------------------------------------------
package pcsa_pkg;

  localparam int SUB_CELL_W = 16;
  localparam int DEPTH_W    = 13;
  localparam int EV_W       = 24;
  localparam int SUM_W      = 32;
  localparam int SHARE_W    = 7;
  localparam int BASE_W     = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int SUBDIV      = 3;

  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SHARE_FRACTION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_BASE      = 1'b1;

  localparam logic [SHARE_W-1:0] SHARE_FRACTION_RESET = 7'd84;
  localparam logic [BASE_W-1:0]  CHIP_BASE_RESET      = 6'd11;

  typedef struct packed {
    logic                  kind;
    logic [SUB_CELL_W-1:0] sub_cell;
    logic [DEPTH_W-1:0]    depth_q4;
    logic [EV_W-1:0]       deposit_ev;
    logic [3:0]            read_chip;
    logic [5:0]            read_column;
    logic [6:0]            read_row;
  } pcsa_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] pixel_sum;
    logic             saturated;
  } pcsa_out_t;

  typedef struct packed {
    logic drop;
    logic h_en;
    logic h_plus;
    logic v_en;
    logic v_plus;
  } pcsa_loc_t;

endpackage

// ----- src/pcsa_stream_if.sv -----
// ----------------------------------------------------------------------------
// pcsa_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface pcsa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, input ready, output payload);
  modport sink   (input valid, output ready, input payload);
endinterface

// ----- src/pcsa_ram.sv -----
// ----------------------------------------------------------------------------
// pcsa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcsa_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- src/pcsa_locate.sv -----
// ----------------------------------------------------------------------------
// pcsa_locate
// Step sequence that turns a deposit into a pixel address, drop flag, share
// directions, share and kept energy.
// ----------------------------------------------------------------------------
module pcsa_locate #(
  parameter  int CHIPS   = 16,
  parameter  int COLUMNS = 52,
  parameter  int ROWS    = 80,
  localparam int ADDR_W  = $clog2(CHIPS * COLUMNS * ROWS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  pcsa_pkg::pcsa_in_t           item,
  input  logic [pcsa_pkg::SHARE_W-1:0] share_fraction,
  input  logic [pcsa_pkg::BASE_W-1:0]  chip_base,
  output logic                         done,
  output pcsa_pkg::pcsa_loc_t          loc,
  output logic [ADDR_W-1:0]            addr,
  output logic [pcsa_pkg::EV_W-1:0]    share,
  output logic [pcsa_pkg::EV_W-1:0]    keep
);
  import pcsa_pkg::*;

  localparam int STAGES    = 8;
  localparam int CHIP_W    = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int LINE_W    = $clog2(CHIPS * COLUMNS);
  localparam int SC        = SUBDIV * COLUMNS;
  localparam int SC2       = 2 * SC;
  localparam int PIX_ROW   = SUBDIV * SC;
  localparam int SUBCOL_W  = $clog2(SC);
  localparam longint unsigned RECIP = (64'd1 << 32) / PIX_ROW;
  localparam int THIRD_MUL   = 683;
  localparam int THIRD_SHIFT = 11;
  localparam logic [1:0] THIRD_LOW  = 2'd0;
  localparam logic [1:0] THIRD_MID  = 2'd1;
  localparam logic [1:0] THIRD_HIGH = 2'd2;

  logic [STAGES-1:0]           stg;
  logic [SUB_CELL_W-1:0]       x;
  logic [47:0]                 prod;
  logic [BASE_W-1:0]           slot;
  logic [30:0]                 sprod;
  logic [EV_W-1:0]             ev;
  logic [SUB_CELL_W-1:0]       q0;
  logic [31:0]                 qd;
  logic                        chip_ok;
  logic [CHIP_W-1:0]           chip;
  logic [SUB_CELL_W-1:0]       r;
  logic [SUB_CELL_W-1:0]       row;
  logic [1:0]                  cy;
  logic [SUBCOL_W-1:0]         subcol;
  logic                        row_ok;
  logic [LINE_W-1:0]           line_base;
  logic [COL_W-1:0]            col;
  logic [1:0]                  cx;
  logic [LINE_W-1:0]           line;
  logic [SUB_CELL_W-1:0]       r0;
  logic [BASE_W:0]             diff;

  assign r0   = x - qd[SUB_CELL_W-1:0];
  assign diff = {1'b0, slot} - {1'b0, chip_base};
  assign done = stg[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else begin
      stg <= {stg[STAGES-2:0], start};
    end

    if (start) begin
      x     <= item.sub_cell;
      prod  <= 48'(item.sub_cell) * 48'(RECIP);
      slot  <= BASE_W'((14'(item.depth_q4) + 14'd128) >> 8);
      sprod <= 31'(item.deposit_ev) * 31'(share_fraction);
      ev    <= item.deposit_ev;
    end

    if (stg[0]) begin
      q0      <= prod[47:32];
      qd      <= 32'(prod[47:32]) * 32'(PIX_ROW);
      share   <= EV_W'((sprod + 31'd128) >> 8);
      chip_ok <= !diff[BASE_W] && (int'(diff) < CHIPS);
      chip    <= CHIP_W'(diff[BASE_W-1:0]);
    end

    if (stg[1]) begin
      if (r0 >= SUB_CELL_W'(PIX_ROW)) begin
        r   <= r0 - SUB_CELL_W'(PIX_ROW);
        row <= q0 + 16'd1;
      end else begin
        r   <= r0;
        row <= q0;
      end
    end

    if (stg[2]) begin
      if (r >= SUB_CELL_W'(SC2)) begin
        cy     <= THIRD_HIGH;
        subcol <= SUBCOL_W'(r - SUB_CELL_W'(SC2));
      end else if (r >= SUB_CELL_W'(SC)) begin
        cy     <= THIRD_MID;
        subcol <= SUBCOL_W'(r - SUB_CELL_W'(SC));
      end else begin
        cy     <= THIRD_LOW;
        subcol <= SUBCOL_W'(r);
      end
      row_ok    <= int'(row) < ROWS;
      line_base <= LINE_W'(int'(chip) * COLUMNS);
    end

    if (stg[3]) begin
      col <= COL_W'((int'(subcol) * THIRD_MUL) >> THIRD_SHIFT);
    end

    if (stg[4]) begin
      cx   <= 2'(int'(subcol) - int'(col) * SUBDIV);
      line <= LINE_W'(int'(line_base) + int'(col));
    end

    if (stg[5]) begin
      addr       <= ADDR_W'(int'(line) * ROWS + int'(row));
      loc.drop   <= !(chip_ok && row_ok);
      loc.h_en   <= (cx == THIRD_LOW && col != '0) ||
                    (cx == THIRD_HIGH && int'(col) != COLUMNS - 1);
      loc.h_plus <= (cx == THIRD_HIGH);
      loc.v_en   <= (cy == THIRD_LOW && row != '0) ||
                    (cy == THIRD_HIGH && int'(row) != ROWS - 1);
      loc.v_plus <= (cy == THIRD_HIGH);
    end

    if (stg[6]) begin
      keep <= ev - (loc.h_en ? share : '0) - (loc.v_en ? share : '0);
    end
  end

endmodule

// ----- src/pixel_charge_share_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// pixel_charge_share_accumulator_core
// Per-chip pixel energy store fed by charge deposits, read and cleared by
// pixel.
// ----------------------------------------------------------------------------
// Items arrive on cmd (valid/ready). A deposit item spreads its energy over
// the hit pixel and up to two neighbours and gives no result; a read item
// returns the pixel's sum on res and clears that pixel. share_fraction and
// chip_base are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// One item is in work at a time; cmd.ready is high only when idle.
// A read steps through line calculation, memory read issue and data capture.
// A deposit runs the address and share calculation, then, unless dropped, one
// read and one write of the single-port pixel memory per updated pixel.
// After reset the store is swept to zero, one entry a cycle, over all
// CHIPS*COLUMNS*ROWS entries (66560 by default) before cmd.ready rises;
// configuration returns to its reset values at once.
// A result waits in the output register while res.ready is low; a following
// read then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module pixel_charge_share_accumulator_core #(
  parameter int CHIPS   = 16,
  parameter int COLUMNS = 52,
  parameter int ROWS    = 80
) (
  input  logic                                clk,
  input  logic                                rst,
  pcsa_stream_if.sink                         cmd,
  pcsa_stream_if.source                       res,
  input  logic                                cfg_we,
  input  logic [pcsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pcsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pcsa_pkg::*;

  localparam int DEPTH  = CHIPS * COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINE_W = $clog2(CHIPS * COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOCATE, S_UPD_RD, S_UPD_WR, S_RD_LINE, S_RD_ISSUE, S_RD_DATA
  } state_t;

  typedef enum logic [1:0] {
    UPD_SIDE, UPD_VERT, UPD_HOME
  } upd_t;

  state_t              state;
  upd_t                step;
  upd_t                step_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   addr_hold;
  pcsa_in_t            item;
  pcsa_out_t           res_item;
  logic                res_valid;
  logic [SHARE_W-1:0]  share_fraction;
  logic [BASE_W-1:0]   chip_base;
  logic                rd_ok;
  logic [LINE_W-1:0]   rd_line;
  logic [ADDR_W-1:0]   rd_addr;
  logic                out_free;

  logic                loc_done;
  pcsa_loc_t           loc;
  logic [ADDR_W-1:0]   loc_addr;
  logic [EV_W-1:0]     loc_share;
  logic [EV_W-1:0]     loc_keep;

  logic                upd_en;
  logic [ADDR_W-1:0]   upd_addr;
  logic [EV_W-1:0]     upd_amount;
  logic [SUM_W:0]      sum;
  logic [SUM_W-1:0]    sat_sum;

  logic                mem_en;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [SUM_W-1:0]    mem_wdata;
  logic [SUM_W-1:0]    mem_rdata;

  pcsa_locate #(
    .CHIPS   (CHIPS),
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_locate (
    .clk            (clk),
    .rst            (rst),
    .start          (cmd.valid && cmd.ready && cmd.payload.kind == KIND_DEPOSIT),
    .item           (cmd.payload),
    .share_fraction (share_fraction),
    .chip_base      (chip_base),
    .done           (loc_done),
    .loc            (loc),
    .addr           (loc_addr),
    .share          (loc_share),
    .keep           (loc_keep)
  );

  pcsa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign res.valid   = res_valid;
  assign res.payload = res_item;
  assign out_free    = !res_valid || res.ready;
  assign rd_addr     = ADDR_W'(int'(rd_line) * ROWS + int'(item.read_row));

  always_comb begin
    unique case (step)
      UPD_SIDE: begin
        upd_en     = loc.h_en;
        upd_addr   = loc.h_plus ? loc_addr + ADDR_W'(ROWS) : loc_addr - ADDR_W'(ROWS);
        upd_amount = loc_share;
        step_next  = UPD_VERT;
      end
      UPD_VERT: begin
        upd_en     = loc.v_en;
        upd_addr   = loc.v_plus ? loc_addr + ADDR_W'(1) : loc_addr - ADDR_W'(1);
        upd_amount = loc_share;
        step_next  = UPD_HOME;
      end
      default: begin
        upd_en     = 1'b1;
        upd_addr   = loc_addr;
        upd_amount = loc_keep;
        step_next  = UPD_HOME;
      end
    endcase
  end

  // Saturating accumulate
  assign sum     = {1'b0, mem_rdata} + (SUM_W + 1)'(upd_amount);
  assign sat_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_hold;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_UPD_RD: begin
        mem_en   = upd_en;
        mem_addr = upd_addr;
      end
      S_UPD_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = sat_sum;
      end
      S_RD_ISSUE: begin
        mem_en   = rd_ok;
        mem_addr = rd_addr;
      end
      S_RD_DATA: begin
        mem_en = rd_ok && out_free;
        mem_we = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      step           <= UPD_SIDE;
      clr_addr       <= '0;
      res_valid      <= 1'b0;
      share_fraction <= SHARE_FRACTION_RESET;
      chip_base      <= CHIP_BASE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHARE_FRACTION: share_fraction <= cfg_data[SHARE_W-1:0];
          CFG_CHIP_BASE:      chip_base      <= cfg_data[BASE_W-1:0];
        endcase
      end

      if (res_valid && res.ready && state != S_RD_DATA) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            item  <= cmd.payload;
            state <= (cmd.payload.kind == KIND_READ) ? S_RD_LINE : S_LOCATE;
          end
        end
        S_LOCATE: begin
          if (loc_done) begin
            step  <= UPD_SIDE;
            state <= loc.drop ? S_IDLE : S_UPD_RD;
          end
        end
        S_UPD_RD: begin
          if (upd_en) begin
            addr_hold <= upd_addr;
            state     <= S_UPD_WR;
          end else begin
            step <= step_next;
          end
        end
        S_UPD_WR: begin
          if (step == UPD_HOME) begin
            state <= S_IDLE;
          end else begin
            step  <= step_next;
            state <= S_UPD_RD;
          end
        end
        S_RD_LINE: begin
          rd_ok   <= (int'(item.read_chip) < CHIPS) && (int'(item.read_column) < COLUMNS) &&
                     (int'(item.read_row) < ROWS);
          rd_line <= LINE_W'(int'(item.read_chip) * COLUMNS + int'(item.read_column));
          state   <= S_RD_ISSUE;
        end
        S_RD_ISSUE: begin
          addr_hold <= rd_addr;
          state     <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (out_free) begin
            res_valid          <= 1'b1;
            res_item.pixel_sum <= rd_ok ? mem_rdata : '0;
            res_item.saturated <= rd_ok && (mem_rdata == '1);
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- src/pcsa_checker.sv -----
// ----------------------------------------------------------------------------
// pcsa_checker
// Port-level assertions for the pixel charge-share accumulator.
// ----------------------------------------------------------------------------
`include "pixel_charge_share_accumulator_core_assert.svh"

module pcsa_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic                res_ready,
  input pcsa_pkg::pcsa_out_t res_item
);

  `PCSA_ASSERT(a_one_item_in_work, (cmd_valid && cmd_ready) |=> !cmd_ready, "item taken while busy")
  `PCSA_ASSERT(a_no_instant_result, (cmd_valid && cmd_ready) |=> !$rose(res_valid), "result too early")
  `PCSA_ASSERT(a_saturation_flag, res_valid |-> (res_item.saturated == (res_item.pixel_sum == '1)), "saturated flag wrong")
  `PCSA_ASSERT(a_result_held, (res_valid && !res_ready) |=> (res_valid && $stable(res_item)), "result dropped while stalled")
  `PCSA_ASSERT_ALWAYS(a_clear_after_reset, rst |=> !cmd_ready, "ready during store clear")

endmodule

bind pixel_charge_share_accumulator_core pcsa_checker u_pcsa_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_item  (res.payload)
);
